@@ hdl/optt_pkg.sv @@
`timescale 1ns / 1ps
package optt_pkg;
   localparam int SLOTS_DEF = 16;
   localparam int MAX_RSP   = 16;
   localparam int NOW_W     = 48;
   localparam int PER_W     = 15;

   localparam logic [2:0] OP_ONCE    = 3'd0;
   localparam logic [2:0] OP_PERIOD  = 3'd1;
   localparam logic [2:0] OP_CANCEL  = 3'd2;
   localparam logic [2:0] OP_CLEAR   = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;
   localparam logic [2:0] OP_START   = 3'd5;
   localparam logic [2:0] OP_STOP    = 3'd6;
   localparam logic [2:0] OP_UNKNOWN = 3'd7;

   localparam logic [2:0] K_ACCEPT = 3'd0;
   localparam logic [2:0] K_REJECT = 3'd1;
   localparam logic [2:0] K_ONCE   = 3'd2;
   localparam logic [2:0] K_PERIOD = 3'd3;
   localparam logic [2:0] K_IDLE   = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] delay;
      logic [31:0]        target_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] tmr_id;
      logic        last;
      logic [4:0]  pending_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0]      id;
      logic [NOW_W-1:0] deadline;
      logic [PER_W-1:0] period;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CAN_RD, ST_CAN_EV, ST_HIT_RD, ST_HIT_EV, ST_SEL_RD, ST_SEL_EV
   } state_type;
endpackage

@@ hdl/oneshot_periodic_timer_table.sv @@
`timescale 1ns / 1ps
// Schedule, cancel all, start, stop, unknown op: result in the cycle after the request.
// Cancel: memory scan, reading and then checking one slot at a time, ending at the first match.
// Tick: full expiry scan, then one full selection scan per fired timer plus one per group.
// One request at a time; busy is high until it ends, for tick maybe after the last result.
// Reset (synchronous): stopped, time 0, next id 1, table empty. Receiver cannot stall.
module oneshot_periodic_timer_table #(
   parameter int SLOTS = optt_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  optt_pkg::req_type req_data,
   output logic              rsp_valid,
   output optt_pkg::rsp_type rsp_data
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   optt_pkg::entry_type mem [SLOTS];
   optt_pkg::entry_type rd_data_ff;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   optt_pkg::entry_type mem_wdata;

   optt_pkg::state_type state_ff, state_in;
   logic [optt_pkg::NOW_W-1:0] now_ff, now_in;
   logic                running_ff, running_in;
   logic [31:0]         next_id_ff, next_id_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [SLOTS-1:0]    hit_ff, hit_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       once_ff, once_in;
   logic [4:0]          sent_ff, sent_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                cls_ff, cls_in;
   logic                found_ff, found_in;
   optt_pkg::entry_type best_ff, best_in;
   logic [IW-1:0]       best_idx_ff, best_idx_in;
   optt_pkg::req_type   req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   optt_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IW-1:0]       free_idx;
   logic                free_ok;
   logic [4:0]          lim;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   assign lim = (int'(total_ff) > optt_pkg::MAX_RSP) ? 5'(optt_pkg::MAX_RSP) : 5'(total_ff);

   always_comb begin
      logic [14:0] d;
      logic        bad;
      logic        sel;
      logic        take;
      state_in     = state_ff;
      now_in       = now_ff;
      running_in   = running_ff;
      next_id_in   = next_id_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      once_in      = once_ff;
      sent_in      = sent_ff;
      idx_in       = idx_ff;
      cls_in       = cls_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = free_idx;
      mem_wdata    = best_ff;
      d            = req_data.delay[15] ? 15'd0 : req_data.delay[14:0];
      bad          = 1'b0;
      sel          = 1'b0;
      take         = 1'b0;
      unique case (state_ff)
         optt_pkg::ST_IDLE: begin
            if (start) begin
               req_in            = req_data;
               rsp_valid_in      = 1'b1;
               rsp_in.kind       = optt_pkg::K_ACCEPT;
               rsp_in.tmr_id     = '0;
               rsp_in.last       = 1'b1;
               priority if (req_data.op == optt_pkg::OP_ONCE ||
                            req_data.op == optt_pkg::OP_PERIOD) begin
                  bad = !running_ff || !free_ok ||
                        (req_data.op == optt_pkg::OP_PERIOD &&
                         (req_data.delay[15] || req_data.delay == '0));
                  if (bad) begin
                     rsp_in.kind = optt_pkg::K_REJECT;
                  end else begin
                     mem_we             = 1'b1;
                     mem_wdata.id       = next_id_ff;
                     mem_wdata.deadline = now_ff + optt_pkg::NOW_W'(d);
                     mem_wdata.period   = (req_data.op == optt_pkg::OP_PERIOD) ? d : '0;
                     valid_in[free_idx] = 1'b1;
                     count_in           = count_ff + 1'b1;
                     rsp_in.tmr_id      = next_id_ff;
                     next_id_in = (next_id_ff == '1) ? 32'd1 : next_id_ff + 32'd1;
                  end
               end else if (req_data.op == optt_pkg::OP_CANCEL) begin
                  if (req_data.target_id == '0) begin
                     rsp_in.kind = optt_pkg::K_REJECT;
                  end else begin
                     rsp_valid_in = 1'b0;
                     idx_in       = '0;
                     state_in     = optt_pkg::ST_CAN_RD;
                  end
               end else if (req_data.op == optt_pkg::OP_CLEAR) begin
                  valid_in = '0;
                  count_in = '0;
               end else if (req_data.op == optt_pkg::OP_TICK) begin
                  rsp_valid_in = 1'b0;
                  now_in       = now_ff + 1'b1;
                  idx_in       = '0;
                  hit_in       = '0;
                  total_in     = '0;
                  once_in      = '0;
                  sent_in      = '0;
                  state_in     = optt_pkg::ST_HIT_RD;
               end else if (req_data.op == optt_pkg::OP_START) begin
                  running_in = 1'b1;
               end else if (req_data.op == optt_pkg::OP_STOP) begin
                  running_in = 1'b0;
                  valid_in   = '0;
                  count_in   = '0;
               end else begin
                  rsp_in.kind = optt_pkg::K_REJECT;
               end
               rsp_in.pending_count = 5'(count_in);
            end
         end
         optt_pkg::ST_CAN_RD: state_in = optt_pkg::ST_CAN_EV;
         optt_pkg::ST_CAN_EV: begin
            rsp_in.tmr_id = '0;
            rsp_in.last   = 1'b1;
            if (valid_ff[idx_ff] && rd_data_ff.id == req_ff.target_id) begin
               valid_in[idx_ff]     = 1'b0;
               count_in             = count_ff - 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = optt_pkg::K_ACCEPT;
               rsp_in.pending_count = 5'(count_in);
               state_in             = optt_pkg::ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = optt_pkg::K_REJECT;
               rsp_in.pending_count = 5'(count_ff);
               state_in             = optt_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = optt_pkg::ST_CAN_RD;
            end
         end
         optt_pkg::ST_HIT_RD: state_in = optt_pkg::ST_HIT_EV;
         optt_pkg::ST_HIT_EV: begin
            if (valid_ff[idx_ff] && rd_data_ff.deadline <= now_ff) begin
               hit_in[idx_ff] = 1'b1;
               total_in       = total_ff + 1'b1;
               if (rd_data_ff.period == '0) begin
                  once_in = once_ff + 1'b1;
               end
            end
            if (idx_ff == LAST_IDX) begin
               count_in = count_ff - once_in;
               idx_in   = '0;
               cls_in   = 1'b0;
               found_in = 1'b0;
               if (total_in == '0) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.kind          = optt_pkg::K_IDLE;
                  rsp_in.tmr_id        = '0;
                  rsp_in.last          = 1'b1;
                  rsp_in.pending_count = 5'(count_in);
                  state_in             = optt_pkg::ST_IDLE;
               end else begin
                  state_in = optt_pkg::ST_SEL_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = optt_pkg::ST_HIT_RD;
            end
         end
         optt_pkg::ST_SEL_RD: state_in = optt_pkg::ST_SEL_EV;
         optt_pkg::ST_SEL_EV: begin
            if (hit_ff[idx_ff] && ((rd_data_ff.period != '0) == cls_ff)) begin
               sel = !found_ff || rd_data_ff.deadline < best_ff.deadline ||
                     (rd_data_ff.deadline == best_ff.deadline && rd_data_ff.id < best_ff.id);
            end
            if (sel) begin
               found_in    = 1'b1;
               best_in     = rd_data_ff;
               best_idx_in = idx_ff;
            end
            take = found_ff || sel;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = optt_pkg::ST_SEL_RD;
               if (take) begin
                  hit_in[best_idx_in] = 1'b0;
                  if (sent_ff < lim) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.kind          = cls_ff ? optt_pkg::K_PERIOD : optt_pkg::K_ONCE;
                     rsp_in.tmr_id        = best_in.id;
                     rsp_in.last          = (sent_ff == lim - 5'd1);
                     rsp_in.pending_count = 5'(count_ff);
                     sent_in              = sent_ff + 5'd1;
                  end
                  if (cls_ff) begin
                     mem_we             = 1'b1;
                     mem_waddr          = best_idx_in;
                     mem_wdata          = best_in;
                     mem_wdata.deadline = now_ff + optt_pkg::NOW_W'(best_in.period);
                  end else begin
                     valid_in[best_idx_in] = 1'b0;
                  end
               end else if (!cls_ff) begin
                  cls_in = 1'b1;
               end else begin
                  state_in = optt_pkg::ST_IDLE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = optt_pkg::ST_SEL_RD;
            end
         end
         default: state_in = optt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= optt_pkg::ST_IDLE;
         now_ff       <= '0;
         running_ff   <= 1'b0;
         next_id_ff   <= 32'd1;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         running_ff   <= running_in;
         next_id_ff   <= next_id_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      total_ff    <= total_in;
      once_ff     <= once_in;
      sent_ff     <= sent_in;
      idx_ff      <= idx_in;
      cls_ff      <= cls_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != optt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
